[hw/rtl/ils_pkg.sv]
// ils_pkg: shared constants and types for the indexed list store
// depends on nothing; imported by indexed_list_store_top
`default_nettype none

package ils_pkg;

  localparam int unsigned DEPTH_DEFAULT      = 16;
  localparam int unsigned DATA_WIDTH_DEFAULT = 32;

  // beat layout widths
  localparam int unsigned CMD_W    = 3;
  localparam int unsigned POS_W    = 4;
  localparam int unsigned WORD_W   = 32;
  localparam int unsigned COUNT_W  = 5;
  localparam int unsigned STATUS_W = 2;
  localparam int unsigned IN_TDATA_W  = 40;
  localparam int unsigned OUT_TDATA_W = 40;

  typedef enum logic [CMD_W-1:0] {
    CMD_GET    = 3'd0,
    CMD_SET    = 3'd1,
    CMD_APPEND = 3'd2,
    CMD_INSERT = 3'd3,
    CMD_REMOVE = 3'd4,
    CMD_CLEAR  = 3'd5
  } cmd_t;

  typedef enum logic [STATUS_W-1:0] {
    STATUS_OK    = 2'd0,
    STATUS_INDEX = 2'd1,
    STATUS_FULL  = 2'd2
  } status_t;

  typedef enum logic [5:0] {
    ST_IDLE   = 6'b000001,
    ST_FETCH  = 6'b000010,
    ST_READ   = 6'b000100,
    ST_MOVE   = 6'b001000,
    ST_PLACE  = 6'b010000,
    ST_FINISH = 6'b100000
  } state_t;

endpackage : ils_pkg

`default_nettype wire

[hw/rtl/indexed_list_store_top.sv]
// indexed_list_store_top: fixed-capacity ordered list with get, set, append,
// insert, remove and clear, shifting entries one at a time through a memory
// depends on ils_pkg
`default_nettype none

// usage
// - input stream s_*: one command beat per list operation
//   s_tdata = {pad, data_word[31:0], position[3:0], command[2:0]}
// - output stream m_*: exactly one result beat per command
//   m_tdata = {pad, status[1:0], entry_count[4:0], read_word[31:0]}
// - one command is in work at a time; s_tready is high only while the
//   sequencer is idle
// - path of a command through the sequencer: set, append, clear, unused
//   codes and failed commands go straight to finish; get passes fetch;
//   insert and remove pass read and move per entry moved, insert then
//   place; the result beat enters the output register as finish is left
// - the entry moves of insert and remove go through the memory's read and
//   write ports, each entry by a registered read, then a write, with
//   one index counter walking the list
// - the result waits in the output register while m_tready is low; the
//   next command may already be accepted, and its result is held back
//   until the output register is free
// - rst (synchronous) empties the list and drops m_tvalid; entry contents
//   are not cleared, since a read is only possible below the count
module indexed_list_store_top
  import ils_pkg::*;
#(
  parameter int unsigned DEPTH      = DEPTH_DEFAULT,
  parameter int unsigned DATA_WIDTH = DATA_WIDTH_DEFAULT
) (
  input  wire logic                   clk,
  input  wire logic                   rst,
  // command[2:0], position[6:3], data_word[38:7], zero pad [39]
  input  wire logic [IN_TDATA_W-1:0]  s_tdata,
  input  wire logic                   s_tvalid,
  output logic                        s_tready,
  // read_word[31:0], entry_count[36:32], status[38:37], zero pad [39]
  output logic [OUT_TDATA_W-1:0]      m_tdata,
  output logic                        m_tvalid,
  input  wire logic                   m_tready
);

  // address, count and compare widths
  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);
  localparam int unsigned XW = (CW > POS_W) ? CW : POS_W;
  localparam int unsigned OW = (CW > COUNT_W) ? CW : COUNT_W;
  // stored bits: anything above the word field is always zero
  localparam int unsigned MW = (DATA_WIDTH < WORD_W) ? DATA_WIDTH : WORD_W;
  localparam logic [CW-1:0] DEPTH_C = CW'(DEPTH);
  localparam logic [OW-1:0] DEPTH_O = OW'(DEPTH);

  // entry storage, one write and one registered read per cycle
  logic [MW-1:0] mem [DEPTH];
  logic [MW-1:0] rd_data;

  state_t           state;
  logic [CW-1:0]    count;
  logic [CW-1:0]    idx;      // walking index of the shift loop
  logic             dir_up;   // insert walks down from count, remove walks up
  logic [CW-1:0]    pos_r;
  logic [MW-1:0]    word_r;
  logic [WORD_W-1:0] res_word;
  status_t          res_status;

  // input beat fields
  logic [CMD_W-1:0]  in_cmd;
  logic [POS_W-1:0]  in_pos;
  logic [WORD_W-1:0] in_word;
  logic [XW-1:0]     pos_x;
  logic [XW-1:0]     cnt_x;
  logic              accept;
  logic              in_range;
  logic              full;
  logic [CW-1:0]     idx_up;
  logic [CW-1:0]     idx_dn;
  logic [CW-1:0]     cnt_dn;
  logic [WORD_W-1:0] rd_ext;
  logic [OW-1:0]     cnt_o;

  logic          wr_en;
  logic [AW-1:0] wr_addr;
  logic [MW-1:0] wr_data;
  logic [AW-1:0] rd_addr;

  assign in_cmd  = s_tdata[CMD_W-1:0];
  assign in_pos  = s_tdata[CMD_W+POS_W-1:CMD_W];
  assign in_word = s_tdata[CMD_W+POS_W+WORD_W-1:CMD_W+POS_W];

  assign s_tready = (state == ST_IDLE);
  assign accept   = s_tvalid && s_tready;

  assign pos_x    = XW'(in_pos);
  assign cnt_x    = XW'(count);
  assign in_range = pos_x < cnt_x;
  assign full     = (count == DEPTH_C);
  assign idx_up   = idx + 1'b1;
  assign idx_dn   = idx - 1'b1;
  assign cnt_dn   = count - 1'b1;
  assign cnt_o    = OW'(count);

  always_comb begin
    rd_ext = '0;
    rd_ext[MW-1:0] = rd_data;
  end

  // read port: the addressed entry for get, the neighbor during a shift
  always_comb begin
    if (state == ST_IDLE) begin
      rd_addr = pos_x[AW-1:0];
    end else if (dir_up) begin
      rd_addr = idx_dn[AW-1:0];
    end else begin
      rd_addr = idx_up[AW-1:0];
    end
  end

  // write port: set and append at accept, moved entries, placed insert word
  always_comb begin
    wr_en   = 1'b0;
    wr_addr = pos_x[AW-1:0];
    wr_data = in_word[MW-1:0];
    unique case (state)
      ST_IDLE: begin
        if (accept && in_cmd == CMD_SET && in_range) begin
          wr_en = 1'b1;
        end else if (accept && in_cmd == CMD_APPEND && !full) begin
          wr_en   = 1'b1;
          wr_addr = count[AW-1:0];
        end
      end
      ST_MOVE: begin
        wr_en   = 1'b1;
        wr_addr = idx[AW-1:0];
        wr_data = rd_data;
      end
      ST_PLACE: begin
        wr_en   = 1'b1;
        wr_addr = pos_r[AW-1:0];
        wr_data = word_r;
      end
      default: begin
        wr_en = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_IDLE;
      count    <= '0;
      m_tvalid <= 1'b0;
    end else begin
      // output register: loaded from the finish state, dropped once taken
      if (state == ST_FINISH && (!m_tvalid || m_tready)) begin
        m_tvalid <= 1'b1;
      end else if (m_tvalid && m_tready) begin
        m_tvalid <= 1'b0;
      end
      unique case (state)
        ST_IDLE: begin
          if (accept) begin
            res_word   <= '0;
            res_status <= STATUS_OK;
            pos_r      <= CW'(pos_x);
            word_r     <= in_word[MW-1:0];
            state      <= ST_FINISH;
            unique case (in_cmd)
              CMD_GET: begin
                if (in_range) begin
                  state <= ST_FETCH;
                end else begin
                  res_status <= STATUS_INDEX;
                end
              end
              CMD_SET: begin
                if (!in_range) begin
                  res_status <= STATUS_INDEX;
                end
              end
              CMD_APPEND: begin
                if (full) begin
                  res_status <= STATUS_FULL;
                end else begin
                  count <= count + 1'b1;
                end
              end
              CMD_INSERT: begin
                if (!in_range) begin
                  res_status <= STATUS_INDEX;
                end else if (full) begin
                  res_status <= STATUS_FULL;
                end else begin
                  idx    <= count;
                  dir_up <= 1'b1;
                  state  <= ST_READ;
                end
              end
              CMD_REMOVE: begin
                if (!in_range) begin
                  res_status <= STATUS_INDEX;
                end else if (pos_x == XW'(cnt_dn)) begin
                  // last entry: nothing to move
                  count <= cnt_dn;
                end else begin
                  idx    <= CW'(pos_x);
                  dir_up <= 1'b0;
                  state  <= ST_READ;
                end
              end
              CMD_CLEAR: begin
                count <= '0;
              end
              default: begin
                res_status <= STATUS_OK;
              end
            endcase
          end
        end
        ST_FETCH: begin
          res_word <= rd_ext;
          state    <= ST_FINISH;
        end
        ST_READ: begin
          state <= ST_MOVE;
        end
        ST_MOVE: begin
          if (dir_up) begin
            idx <= idx_dn;
            if (idx_dn == pos_r) begin
              state <= ST_PLACE;
            end else begin
              state <= ST_READ;
            end
          end else begin
            idx <= idx_up;
            if (idx_up == cnt_dn) begin
              count <= cnt_dn;
              state <= ST_FINISH;
            end else begin
              state <= ST_READ;
            end
          end
        end
        ST_PLACE: begin
          count <= count + 1'b1;
          state <= ST_FINISH;
        end
        ST_FINISH: begin
          // hold the result until the output register is free
          if (!m_tvalid || m_tready) begin
            m_tdata  <= {1'b0, res_status, cnt_o[COUNT_W-1:0], res_word};
            state    <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  // checks
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= DEPTH_C)
    else $error("entry count above capacity");

  a_full_count: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tdata[OUT_TDATA_W-2:OUT_TDATA_W-1-STATUS_W] == STATUS_FULL)
      |-> m_tdata[WORD_W+COUNT_W-1:WORD_W] == DEPTH_O[COUNT_W-1:0])
    else $error("full status with count below capacity");

  a_insert_walk: assert property (@(posedge clk) disable iff (rst)
    (state == ST_MOVE && dir_up) |-> (idx > pos_r && idx <= count))
    else $error("insert shift index out of range");

  a_remove_walk: assert property (@(posedge clk) disable iff (rst)
    (state == ST_MOVE && !dir_up) |-> (idx_up < count))
    else $error("remove shift index out of range");

  a_result_hold: assert property (@(posedge clk) disable iff (rst)
    (state == ST_FINISH && m_tvalid && !m_tready) |=> state == ST_FINISH)
    else $error("result loaded over a waiting beat");

endmodule : indexed_list_store_top

`default_nettype wire
